// File: sv/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

	localparam int NUM_SLOTS = 8192;
	localparam int WORD_BITS = 32;
	localparam int NWORDS    = NUM_SLOTS / WORD_BITS;
	localparam int IDX_W     = $clog2(NWORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int SLOT_W    = 13;
	localparam int SEL_W     = 16;
	localparam int STATUS_W  = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;

	typedef struct packed {
		logic load;
		logic rd_free;
		logic rd_first;
		logic rd_next;
		logic wr_clear;
		logic wr_set;
		logic emit_free;
		logic emit_alloc;
		logic emit_full;
	} bsa_cmd_t;

	typedef struct packed {
		logic word_full;
		logic last_word;
	} bsa_sts_t;

endpackage

`default_nettype wire

// File: sv/bsa_ctrl.sv
`default_nettype none

module bsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              opcode,
	input  wire bsa_pkg::bsa_sts_t sts,
	output bsa_pkg::bsa_cmd_t      cmd,
	output logic                   busy
);
	import bsa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_FREE_RD  = 5'b00010,
		S_FREE_WR  = 5'b00100,
		S_SCAN_RD  = 5'b01000,
		S_SCAN_CHK = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (opcode == OP_FREE) ? S_FREE_RD : S_SCAN_RD;
				end
			end
			S_FREE_RD: begin
				cmd.rd_free = 1'b1;
				state_d     = S_FREE_WR;
			end
			S_FREE_WR: begin
				cmd.wr_clear  = 1'b1;
				cmd.emit_free = 1'b1;
				state_d       = S_IDLE;
			end
			S_SCAN_RD: begin
				cmd.rd_first = 1'b1;
				state_d      = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (!sts.word_full) begin
					cmd.wr_set     = 1'b1;
					cmd.emit_alloc = 1'b1;
					state_d        = S_IDLE;
				end else if (sts.last_word) begin
					cmd.emit_full = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/bsa_dp.sv
`default_nettype none

module bsa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bsa_pkg::bsa_cmd_t             cmd,
	input  wire logic [bsa_pkg::SLOT_W-1:0]    slot_to_free,
	output bsa_pkg::bsa_sts_t                  sts,
	output logic                               done,
	output logic [bsa_pkg::SLOT_W-1:0]         slot,
	output logic [bsa_pkg::SEL_W-1:0]          selector,
	output logic [bsa_pkg::STATUS_W-1:0]       status
);
	import bsa_pkg::*;

	logic [WORD_BITS-1:0] mem [NWORDS];
	logic [NWORDS-1:0]    valid_q;

	logic [SLOT_W-1:0]    req_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;

	logic                 done_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [SEL_W-1:0]     res_sel_q;
	logic [STATUS_W-1:0]  res_status_q;

	logic [WORD_BITS-1:0] word;
	logic [BIT_W-1:0]     free_bit;
	logic [BIT_W-1:0]     req_bit;
	logic [IDX_W-1:0]     req_idx;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;
	logic [SLOT_W-1:0]    alloc_slot;

	// A word that has never been written reads as all slots free.
	assign word    = rvld_q ? rdata_q : '0;
	assign req_idx = req_q[BIT_W +: IDX_W];
	assign req_bit = req_q[BIT_W-1:0];

	always_comb begin
		free_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!word[b]) begin
				free_bit = BIT_W'(b);
			end
		end
	end

	assign sts.word_full = &word;
	assign sts.last_word = (idx_q == IDX_W'(NWORDS - 1));

	assign alloc_slot = SLOT_W'({idx_q, free_bit});

	always_comb begin
		rd_en   = cmd.rd_free | cmd.rd_first | cmd.rd_next;
		rd_addr = idx_q + IDX_W'(1);
		if (cmd.rd_free) begin
			rd_addr = req_idx;
		end else if (cmd.rd_first) begin
			rd_addr = '0;
		end
	end

	always_comb begin
		wr_en   = cmd.wr_clear | cmd.wr_set;
		wr_addr = cmd.wr_clear ? req_idx : idx_q;
		wr_data = cmd.wr_clear ? (word & ~(WORD_BITS'(1) << req_bit))
		                       : (word | (WORD_BITS'(1) << free_bit));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= slot_to_free;
		end
		if (cmd.rd_first) begin
			idx_q <= '0;
		end else if (cmd.rd_next) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_free | cmd.emit_alloc | cmd.emit_full;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_free) begin
			res_slot_q   <= req_q;
			res_sel_q    <= '0;
			res_status_q <= STATUS_FREED;
		end else if (cmd.emit_alloc) begin
			res_slot_q   <= alloc_slot;
			res_sel_q    <= SEL_W'({alloc_slot, 3'b111});
			res_status_q <= STATUS_ALLOC;
		end else if (cmd.emit_full) begin
			res_slot_q   <= '0;
			res_sel_q    <= '0;
			res_status_q <= STATUS_FULL;
		end
	end

	assign done     = done_q;
	assign slot     = res_slot_q;
	assign selector = res_sel_q;
	assign status   = res_status_q;

endmodule

`default_nettype wire

// File: sv/bitmap_slot_allocator.sv
`default_nettype none

// Allocates and frees slots of an 8192-entry bitmap, all free after reset. A transfer
// starts when start is high while busy is low; opcode 0 allocates the lowest free slot
// and opcode 1 frees slot_to_free. Each request gives exactly one result, shown for a
// single cycle with done high, which the receiver must take then since it cannot stall.
// A free reads the word that holds its slot, then writes it back with that bit cleared.
// An allocate reads one 32-bit bitmap word per cycle from the lowest word upward until
// one of them has a free slot or the last word is found full. Busy is already low in the
// cycle that shows done, so the next request is taken at the edge that ends it.

module bitmap_slot_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          opcode,
	input  wire logic [bsa_pkg::SLOT_W-1:0]    slot_to_free,
	output logic                               done,
	output logic [bsa_pkg::SLOT_W-1:0]         slot,
	output logic [bsa_pkg::SEL_W-1:0]          selector,
	output logic [bsa_pkg::STATUS_W-1:0]       status
);
	import bsa_pkg::*;

	bsa_cmd_t cmd;
	bsa_sts_t sts;
	logic     ctrl_start;

	assign ctrl_start = start & ~busy;

	bsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl_start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.slot_to_free (slot_to_free),
		.sts          (sts),
		.done         (done),
		.slot         (slot),
		.selector     (selector),
		.status       (status)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	a_done_frees_block: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("block still busy while its result is shown");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not make the block busy");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_FULL |-> slot == '0 && selector == '0)
		else $error("full result carries a slot");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == STATUS_ALLOC || status == STATUS_FULL || status == STATUS_FREED)
		else $error("undefined status code");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;
	import bsa_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [SEL_W-1:0]    selector;
		logic [STATUS_W-1:0] status;
	} slot_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                opcode = OP_ALLOC;
	logic [SLOT_W-1:0]   slot_to_free = '0;
	logic                busy;
	logic                done;
	logic [SLOT_W-1:0]   slot;
	logic [SEL_W-1:0]    selector;
	logic [STATUS_W-1:0] status;

	logic [WORD_BITS-1:0] used_map [NWORDS];
	slot_result_t         pending_results [$];
	logic [SLOT_W-1:0]    held_slots [$];
	logic                 last_alloc_full = 1'b0;
	int                   idle_pct = 0;
	int                   mismatch_count = 0;

	bitmap_slot_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.slot_to_free(slot_to_free),
		.done(done),
		.slot(slot),
		.selector(selector),
		.status(status)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Mirrors the bitmap: a free clears the bit, an allocate sets the lowest clear bit
	// of the first word that is not full.
	task automatic predict_request(input logic op, input logic [SLOT_W-1:0] s);
		slot_result_t r;
		int w;
		int b;
		logic found;
		r = '0;
		found = 1'b0;
		if (op == OP_FREE) begin
			if (int'(s) / WORD_BITS < NWORDS)
				used_map[int'(s) / WORD_BITS][int'(s) % WORD_BITS] = 1'b0;
			r.slot = s;
			r.status = STATUS_FREED;
		end else begin
			w = 0;
			while (w < NWORDS && !found) begin
				if (used_map[w] != '1) begin
					b = 0;
					while (used_map[w][b])
						b++;
					used_map[w][b] = 1'b1;
					r.slot = SLOT_W'(w * WORD_BITS + b);
					r.selector = SEL_W'((w * WORD_BITS + b) * 8 + 7);
					r.status = STATUS_ALLOC;
					held_slots.push_back(r.slot);
					found = 1'b1;
				end
				w++;
			end
			if (!found)
				r.status = STATUS_FULL;
			last_alloc_full = !found;
		end
		pending_results.push_back(r);
	endtask

	function automatic int pick_gap();
		int n;
		n = 0;
		while ($urandom_range(99) < idle_pct)
			n++;
		return n;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is accepted.
	task automatic send_request(input logic op, input logic [SLOT_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		slot_to_free <= s;
		do @(posedge clk); while (busy);
		predict_request(op, s);
		@(negedge clk);
	endtask

	task automatic send_free_of_held();
		int idx;
		logic [SLOT_W-1:0] s;
		if (held_slots.size() == 0) begin
			send_request(OP_FREE, SLOT_W'($urandom));
		end else begin
			idx = $urandom_range(held_slots.size() - 1);
			s = held_slots[idx];
			held_slots.delete(idx);
			send_request(OP_FREE, s);
		end
	endtask

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (slot !== want.slot)
					report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
				if (selector !== want.selector)
					report_mismatch($sformatf("selector %0d, expected %0d",
						selector, want.selector));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
			end
		end
	end

	task automatic test_alloc_free_basics();
		repeat (3)
			send_request(OP_ALLOC, SLOT_W'($urandom));
		send_request(OP_FREE, SLOT_W'(1));
		send_request(OP_ALLOC, '1);
		send_request(OP_FREE, SLOT_W'(1));
		send_request(OP_FREE, SLOT_W'(1));
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_FREE, '1);
		send_request(OP_ALLOC, SLOT_W'($urandom));
		send_request(OP_FREE, SLOT_W'(5000));
		send_request(OP_FREE, SLOT_W'(2));
		send_request(OP_ALLOC, SLOT_W'($urandom));
		send_request(OP_ALLOC, SLOT_W'($urandom));
	endtask

	// Mostly allocations and frees of slots in use, with frees of arbitrary slots mixed in.
	task automatic test_random_traffic(input int count, input int pct);
		int pick;
		idle_pct = pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 55)
				send_request(OP_ALLOC, SLOT_W'($urandom));
			else if (pick < 90)
				send_free_of_held();
			else
				send_request(OP_FREE, SLOT_W'($urandom));
		end
	endtask

	task automatic test_table_full();
		idle_pct = 0;
		do
			send_request(OP_ALLOC, SLOT_W'($urandom));
		while (!last_alloc_full);
		send_request(OP_ALLOC, '1);
		send_request(OP_FREE, SLOT_W'(NUM_SLOTS - 1));
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_FREE, SLOT_W'(4000));
		send_request(OP_ALLOC, SLOT_W'($urandom));
		send_request(OP_ALLOC, SLOT_W'($urandom));
		send_request(OP_ALLOC, SLOT_W'($urandom));
	endtask

	initial begin
		foreach (used_map[i])
			used_map[i] = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 30;
		test_alloc_free_basics();
		test_random_traffic(510, 30);
		test_random_traffic(510, 76);
		test_random_traffic(510, 0);
		test_table_full();
		test_random_traffic(150, 30);
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#120000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
